// ===== hw/rtl/ful_pkg.sv =====
// Shared types and constants for the Frenet unicycle linearizer.
package ful_pkg;

    localparam int ANG_W  = 34;
    localparam int TRIG_W = 20;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [15:0] TIME_STEP_RESET = 16'd3277;

    localparam logic [31:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Input word, first field in the highest bits.
    typedef struct packed {
        logic signed [15:0] path_turn;
        logic signed [15:0] speed;
        logic signed [15:0] heading_error;
    } ful_side_t;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic signed [15:0] resid_theta;
        logic signed [31:0] resid_ey;
        logic signed [31:0] resid_s;
        logic signed [31:0] b_ey_speed;
        logic signed [31:0] b_s_speed;
        logic signed [31:0] a_ey_theta;
        logic signed [31:0] a_s_theta;
    } ful_result_t;

endpackage

// ===== hw/rtl/ful_cordic.sv =====
// Range reduction, unrolled rotation CORDIC and rounding of cosine and sine to Q1.16.
module ful_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  ful_pkg::ful_side_t    in_side,
    output logic                  out_valid,
    output ful_pkg::ful_side_t    out_side,
    output logic signed [ful_pkg::TRIG_W-1:0] out_cos,
    output logic signed [ful_pkg::TRIG_W-1:0] out_sin
);
    import ful_pkg::*;

    localparam int NS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    logic                    vld_reg  [0:NS];
    logic signed [ANG_W-1:0] x_reg    [0:NS];
    logic signed [ANG_W-1:0] y_reg    [0:NS];
    logic signed [ANG_W-1:0] z_reg    [0:NS];
    logic                    neg_reg  [0:NS];
    ful_side_t               side_reg [0:NS];

    logic signed [ANG_W-1:0] z_wide;
    logic signed [ANG_W-1:0] z0_next;
    logic                    neg0_next;

    always_comb begin
        z_wide = {in_side.heading_error[15], in_side.heading_error, 17'b0};
        z0_next = z_wide;
        neg0_next = 1'b0;
        if (z_wide > HALF_PI_Q30) begin
            z0_next = z_wide - PI_Q30;
            neg0_next = 1'b1;
        end else if (z_wide < -HALF_PI_Q30) begin
            z0_next = z_wide + PI_Q30;
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            neg_reg[0]  <= neg0_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic signed [ANG_W-1:0] x_next;
        logic signed [ANG_W-1:0] y_next;
        logic signed [ANG_W-1:0] z_next;
        logic signed [ANG_W-1:0] dx;
        logic signed [ANG_W-1:0] dy;
        logic signed [ANG_W-1:0] da;

        always_comb begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            da = $signed({{(ANG_W-32){1'b0}}, ATAN_Q30[i]});
            if (z_reg[i] >= 0) begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - da;
            end else begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + da;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                neg_reg[i+1]  <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    logic signed [ANG_W-1:0] xf;
    logic signed [ANG_W-1:0] yf;
    logic signed [ANG_W-1:0] xr;
    logic signed [ANG_W-1:0] yr;
    logic                    vld_out_reg;
    ful_side_t               side_out_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    always_comb begin
        xf = neg_reg[NS] ? -x_reg[NS] : x_reg[NS];
        yf = neg_reg[NS] ? -y_reg[NS] : y_reg[NS];
        xr = xf + ANG_W'(15'sd8192);
        yr = yf + ANG_W'(15'sd8192);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (en) begin
            vld_out_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_out_reg <= side_reg[NS];
            cos_reg      <= xr[ANG_W-1:14];
            sin_reg      <= yr[ANG_W-1:14];
        end
    end

    assign out_valid = vld_out_reg;
    assign out_side  = side_out_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

// ===== hw/rtl/ful_jacobian.sv =====
// Three-stage multiplier pipeline that forms the scaled Jacobian and residual entries.
module ful_jacobian (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [15:0]           time_step,
    input  logic                  in_valid,
    input  ful_pkg::ful_side_t    in_side,
    input  logic signed [ful_pkg::TRIG_W-1:0] in_cos,
    input  logic signed [ful_pkg::TRIG_W-1:0] in_sin,
    output logic                  out_valid,
    output ful_pkg::ful_result_t  out_result
);
    import ful_pkg::*;

    localparam int TD_W = TRIG_W + 17;
    localparam int VT_W = TD_W + 16;
    localparam int VE_W = 32;
    localparam int RS_W = TD_W + VE_W;

    localparam logic signed [TD_W-1:0] RND_B = TD_W'(1) <<< 7;
    localparam logic signed [VT_W-1:0] RND_A = VT_W'(1) <<< 19;
    localparam logic signed [RS_W-1:0] RND_D = RS_W'(1) <<< 32;

    logic signed [16:0] dt_s;
    assign dt_s = $signed({1'b0, time_step});

    // Stage 1: trig times dt, speed times heading.
    logic                    v1_reg;
    logic signed [TD_W-1:0]  cd_reg;
    logic signed [TD_W-1:0]  sd_reg;
    logic signed [VE_W-1:0]  ve_reg;
    logic signed [15:0]      spd1_reg;
    logic signed [15:0]      turn1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_reg    <= in_cos * dt_s;
            sd_reg    <= in_sin * dt_s;
            ve_reg    <= in_side.speed * in_side.heading_error;
            spd1_reg  <= in_side.speed;
            turn1_reg <= in_side.path_turn;
        end
    end

    // Stage 2: full products and the B entries.
    logic                    v2_reg;
    logic signed [VT_W-1:0]  vcd_reg;
    logic signed [VT_W-1:0]  vsd_reg;
    logic signed [RS_W-1:0]  vecd_reg;
    logic signed [RS_W-1:0]  vesd_reg;
    logic signed [31:0]      bs2_reg;
    logic signed [31:0]      bey2_reg;
    logic signed [15:0]      turn2_reg;
    logic signed [TD_W-1:0]  cd_rnd;
    logic signed [TD_W-1:0]  sd_rnd;

    always_comb begin
        cd_rnd = (cd_reg + RND_B) >>> 8;
        sd_rnd = (sd_reg + RND_B) >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vcd_reg   <= spd1_reg * cd_reg;
            vsd_reg   <= spd1_reg * sd_reg;
            vecd_reg  <= ve_reg * cd_reg;
            vesd_reg  <= ve_reg * sd_reg;
            bs2_reg   <= cd_rnd[31:0];
            bey2_reg  <= sd_rnd[31:0];
            turn2_reg <= turn1_reg;
        end
    end

    // Stage 3: rounding to Q8.24 and the negated path turn.
    logic                    v3_reg;
    ful_result_t             res_reg;
    ful_result_t             res_next;
    logic signed [VT_W-1:0]  as_t;
    logic signed [VT_W-1:0]  aey_t;
    logic signed [RS_W-1:0]  rs_t;
    logic signed [RS_W-1:0]  rey_t;

    always_comb begin
        as_t  = (RND_A - vsd_reg) >>> 20;
        aey_t = (vcd_reg + RND_A) >>> 20;
        rs_t  = (vesd_reg + RND_D) >>> 33;
        rey_t = (RND_D - vecd_reg) >>> 33;
        res_next.a_s_theta  = as_t[31:0];
        res_next.a_ey_theta = aey_t[31:0];
        res_next.b_s_speed  = bs2_reg;
        res_next.b_ey_speed = bey2_reg;
        res_next.resid_s    = rs_t[31:0];
        res_next.resid_ey   = rey_t[31:0];
        if (turn2_reg == 16'sh8000) begin
            res_next.resid_theta = 16'sh7FFF;
        end else begin
            res_next.resid_theta = -turn2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_result = res_reg;

endmodule

// ===== hw/rtl/ful_skid.sv =====
// Output register with a skid stage so that upstream ready comes from a register.
module ful_skid (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ful_pkg::ful_result_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ful_pkg::ful_result_t  out_data
);
    import ful_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    ful_result_t out_data_reg;
    ful_result_t skid_data_reg;
    logic        in_fire;
    logic        out_load;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_load = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/frenet_unicycle_linearizer_core.sv =====
// Top level of the Frenet unicycle linearizer: config register, CORDIC, multipliers, output.
//
// Channel   Direction  Content
// s_axis    in         heading_error, speed, path_turn
// m_axis    out        A, B and residual entries, one word per input word
// time_step in         dt register, written with time_step_we
//
// One word is accepted every cycle while s_axis_tready is high. m_axis_tvalid is set
// through the input register, the unrolled CORDIC stages, the rounding register, the
// three multiplier stages and the output register. Reset clears all valid bits and
// loads dt with 3277.
// A stall on m_axis fills the skid stage, after which s_axis_tready drops and the
// whole pipeline holds; no word is lost or repeated.
module frenet_unicycle_linearizer_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // heading_error [15:0], speed [31:16], path_turn [47:32]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // a_s_theta [31:0], a_ey_theta [63:32], b_s_speed [95:64], b_ey_speed [127:96],
    // resid_s [159:128], resid_ey [191:160], resid_theta [207:192]
    output logic [207:0] m_axis_tdata,
    input  logic         time_step_we,
    input  logic [15:0]  time_step_wdata
);
    import ful_pkg::*;

    logic [15:0] time_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RESET;
        end else if (time_step_we) begin
            time_step_reg <= time_step_wdata;
        end
    end

    logic                     en;
    logic                     cor_valid;
    ful_side_t                cor_side;
    logic signed [TRIG_W-1:0] cor_cos;
    logic signed [TRIG_W-1:0] cor_sin;
    logic                     jac_valid;
    ful_result_t              jac_result;
    ful_result_t              out_result;

    assign s_axis_tready = en;

    ful_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_side   (ful_side_t'(s_axis_tdata)),
        .out_valid (cor_valid),
        .out_side  (cor_side),
        .out_cos   (cor_cos),
        .out_sin   (cor_sin)
    );

    ful_jacobian u_jacobian (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .time_step  (time_step_reg),
        .in_valid   (cor_valid),
        .in_side    (cor_side),
        .in_cos     (cor_cos),
        .in_sin     (cor_sin),
        .out_valid  (jac_valid),
        .out_result (jac_result)
    );

    ful_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (jac_valid),
        .in_ready  (en),
        .in_data   (jac_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = out_result;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Frenet unicycle linearizer core with a result scoreboard.
import ful_pkg::*;

class linearizer_scoreboard;
    localparam longint PI_Q30_L = 64'sd3373259426;
    localparam longint HALF_PI_Q30_L = 64'sd1686629713;
    localparam longint GAIN_Q30_L = 64'sd652032874;

    logic [15:0] time_step;
    int stages;
    int fail_count;
    longint arctan_q30 [24];
    ful_result_t jacobian_q [$];

    function new(int n_stages);
        stages = n_stages;
        time_step = TIME_STEP_RESET;
        fail_count = 0;
        arctan_q30 = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
        };
    endfunction

    function longint round_drop(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Rotation-mode CORDIC with a half-turn fold, rounded from Q1.30 to Q1.16.
    function void heading_sincos(longint e, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        z = e * 131072;
        x = GAIN_Q30_L;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q30_L) begin
            z = z - PI_Q30_L;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30_L) begin
            z = z + PI_Q30_L;
            flip = 1'b1;
        end
        for (int i = 0; i < stages && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q30[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q30[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_drop(x, 14);
        s = round_drop(y, 14);
    endfunction

    function ful_result_t linearize(ful_side_t w);
        ful_result_t r;
        longint e;
        longint v;
        longint t;
        longint dt;
        longint c;
        longint s;
        longint p;
        e = longint'($signed(w.heading_error));
        v = longint'($signed(w.speed));
        t = longint'($signed(w.path_turn));
        dt = longint'({48'd0, time_step});
        heading_sincos(e, c, s);
        p = round_drop(-(v * s * dt), 20);
        r.a_s_theta = p[31:0];
        p = round_drop(v * c * dt, 20);
        r.a_ey_theta = p[31:0];
        p = round_drop(c * dt, 8);
        r.b_s_speed = p[31:0];
        p = round_drop(s * dt, 8);
        r.b_ey_speed = p[31:0];
        p = round_drop(v * s * e * dt, 33);
        r.resid_s = p[31:0];
        p = round_drop(-(v * c * e * dt), 33);
        r.resid_ey = p[31:0];
        p = -t;
        if (p > 32767) begin
            p = 32767;
        end
        r.resid_theta = p[15:0];
        return r;
    endfunction

    function void note_step(ful_side_t w);
        jacobian_q.push_back(linearize(w));
    endfunction

    function void compare(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function void check_word(ful_result_t got);
        ful_result_t want;
        if (jacobian_q.size() == 0) begin
            $error("result word with no input waiting: %h", got);
            fail_count++;
            return;
        end
        want = jacobian_q.pop_front();
        compare("a_s_theta", longint'($signed(want.a_s_theta)), longint'($signed(got.a_s_theta)));
        compare("a_ey_theta", longint'($signed(want.a_ey_theta)),
                longint'($signed(got.a_ey_theta)));
        compare("b_s_speed", longint'($signed(want.b_s_speed)), longint'($signed(got.b_s_speed)));
        compare("b_ey_speed", longint'($signed(want.b_ey_speed)),
                longint'($signed(got.b_ey_speed)));
        compare("resid_s", longint'($signed(want.resid_s)), longint'($signed(got.resid_s)));
        compare("resid_ey", longint'($signed(want.resid_ey)), longint'($signed(got.resid_ey)));
        compare("resid_theta", longint'($signed(want.resid_theta)),
                longint'($signed(got.resid_theta)));
    endfunction

    function int pending();
        return jacobian_q.size();
    endfunction
endclass

module tb;
    localparam int STAGES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 150;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;
    logic         time_step_we = 1'b0;
    logic [15:0]  time_step_wdata = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;
    int cycle_count = 0;

    linearizer_scoreboard sb = new(STAGES);

    frenet_unicycle_linearizer_core #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .time_step_we(time_step_we),
        .time_step_wdata(time_step_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    function automatic ful_side_t random_step();
        ful_side_t w;
        logic signed [15:0] angle_corner [8];
        logic signed [15:0] speed_corner [6];
        angle_corner = '{16'sd0, 16'sd12867, 16'sd12868, -16'sd12867, -16'sd12868,
                         16'sd25736, -16'sd25736, 16'sh7FFF};
        speed_corner = '{16'sd0, 16'sd4096, -16'sd4096, 16'sd32767, -16'sd32768, 16'sd1};
        case ($urandom_range(9))
            0: w.heading_error = 16'($urandom);
            1: w.heading_error = angle_corner[$urandom_range(7)];
            default: w.heading_error = 16'(int'($urandom_range(51472)) - 25736);
        endcase
        case ($urandom_range(9))
            0: w.speed = speed_corner[$urandom_range(5)];
            default: w.speed = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0: w.path_turn = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            1: w.path_turn = 16'($urandom);
            default: w.path_turn = 16'(int'($urandom_range(51472)) - 25736);
        endcase
        return w;
    endfunction

    task automatic send_word(input ful_side_t w);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_step(w);
    endtask

    task automatic send_fields(input logic [15:0] e, input logic [15:0] v,
                               input logic [15:0] t);
        ful_side_t w;
        w.heading_error = e;
        w.speed = v;
        w.path_turn = t;
        send_word(w);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_time_step(input logic [15:0] value);
        time_step_we <= 1'b1;
        time_step_wdata <= value;
        @(posedge aclk);
        time_step_we <= 1'b0;
        sb.time_step = value;
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            rx_hold <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tdata);
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [15:0] dt_plan [7];
        dt_plan = '{TIME_STEP_RESET, 16'd0, 16'hFFFF, 16'd1, 16'h8000,
                    16'($urandom), 16'($urandom)};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The directed words run at the reset time step.
        tx_idle_pct = 20;
        rx_stall_pct = 20;
        send_fields(16'sd0, 16'sd0, 16'sd0);
        send_fields(16'sd0, 16'sd4096, 16'sd1);
        send_fields(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_fields(16'sh8000, 16'sh8000, 16'sh8000);
        send_fields(16'sd25736, 16'sh7FFF, 16'sd25736);
        send_fields(-16'sd25736, 16'sh8000, -16'sd25736);
        send_fields(16'sd12867, 16'sd4096, 16'sd100);
        send_fields(16'sd12868, 16'sd4096, -16'sd100);
        send_fields(-16'sd12867, -16'sd4096, 16'sd0);
        send_fields(-16'sd12868, -16'sd4096, 16'sh8000);
        send_fields(16'sd6434, 16'sh7FFF, -16'sd1);
        send_fields(-16'sd6434, 16'sh8000, 16'sd1);
        send_fields(16'sd30000, 16'sd20000, 16'sd5);
        send_fields(-16'sd30000, -16'sd20000, -16'sd5);
        send_fields(-16'sd1, 16'sd1, 16'shFFFF);
        send_fields(16'sd1, -16'sd1, 16'sd25736);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                drain_results();
                write_time_step(dt_plan[p]);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    tx_idle_pct = pick_pct();
                    rx_stall_pct = pick_pct();
                end
                send_word(random_step());
            end
        end

        drain_results();
        repeat (STAGES + 10) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/ful_pkg.sv
hw/rtl/ful_cordic.sv
hw/rtl/ful_jacobian.sv
hw/rtl/ful_skid.sv
hw/rtl/frenet_unicycle_linearizer_core.sv
dv/tb.sv
